FILE: rtl/core/gpl_pkg.sv
`timescale 1ns / 1ps

package gpl_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned PINS    = 16;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned NIB_W   = 4;
    localparam int unsigned HALF    = PINS / 2;
    localparam int unsigned KEY_BIT = PINS;

    localparam logic [DATA_W-1:0] CFG_RESET = 32'h4444_4444;
    localparam logic [NIB_W-1:0]  NIBBLE    = 4'hF;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [IDX_W-1:0] REG_CFG_LOW   = 3'd0;
    localparam logic [IDX_W-1:0] REG_CFG_HIGH  = 3'd1;
    localparam logic [IDX_W-1:0] REG_INPUT     = 3'd2;
    localparam logic [IDX_W-1:0] REG_OUTPUT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_SET_RESET = 3'd4;
    localparam logic [IDX_W-1:0] REG_RESET     = 3'd5;
    localparam logic [IDX_W-1:0] REG_LOCK      = 3'd6;

    localparam logic [1:0] STG_IDLE = 2'd0;
    localparam logic [1:0] STG_ONE  = 2'd1;
    localparam logic [1:0] STG_TWO  = 2'd2;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] write_data;
        logic [PINS-1:0]   pin_levels;
    } t_access;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              lock_active;
    } t_result;

    // one nibble per locked pin of a half port
    function automatic logic [DATA_W-1:0] frozen_mask(input logic [HALF-1:0] locked);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < HALF; i++) begin
            if (locked[i]) begin
                m[i*NIB_W +: NIB_W] = NIBBLE;
            end
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/gpl_regfile.sv
`timescale 1ns / 1ps

module gpl_regfile
    import gpl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_access i_acc,
    output t_result o_res
);

    logic [DATA_W-1:0] r_cfg_low,  n_cfg_low;
    logic [DATA_W-1:0] r_cfg_high, n_cfg_high;
    logic [PINS-1:0]   r_out_bits, n_out_bits;
    logic [PINS-1:0]   r_lock_bits, n_lock_bits;
    logic              r_lock_key, n_lock_key;
    logic [1:0]        r_stage, n_stage;

    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] m_low;
    logic [DATA_W-1:0] m_high;
    logic [PINS-1:0]   wd_lo;
    logic [PINS-1:0]   wd_hi;
    logic              key;
    logic              same;

    assign wd_lo  = i_acc.write_data[PINS-1:0];
    assign wd_hi  = i_acc.write_data[DATA_W-1:PINS];
    assign key    = i_acc.write_data[KEY_BIT];
    assign same   = (wd_lo == r_lock_bits);
    assign m_low  = r_lock_key ? frozen_mask(r_lock_bits[HALF-1:0]) : '0;
    assign m_high = r_lock_key ? frozen_mask(r_lock_bits[PINS-1:HALF]) : '0;

    always_comb begin
        n_cfg_low   = r_cfg_low;
        n_cfg_high  = r_cfg_high;
        n_out_bits  = r_out_bits;
        n_lock_bits = r_lock_bits;
        n_lock_key  = r_lock_key;
        n_stage     = r_stage;
        rd          = '0;
        if (i_acc.op == OP_READ) begin
            unique case (i_acc.reg_index)
                REG_CFG_LOW:  rd = r_cfg_low;
                REG_CFG_HIGH: rd = r_cfg_high;
                REG_INPUT:    rd = {{(DATA_W-PINS){1'b0}}, i_acc.pin_levels};
                REG_OUTPUT:   rd = {{(DATA_W-PINS){1'b0}}, r_out_bits};
                REG_LOCK:     rd = {{(DATA_W-PINS-1){1'b0}}, r_lock_key, r_lock_bits};
                default:      rd = '0;
            endcase
        end else begin
            unique case (i_acc.reg_index)
                REG_CFG_LOW:   n_cfg_low  = (r_cfg_low & m_low) | (i_acc.write_data & ~m_low);
                REG_CFG_HIGH:  n_cfg_high = (r_cfg_high & m_high)
                                          | (i_acc.write_data & ~m_high);
                REG_OUTPUT:    n_out_bits = wd_lo;
                REG_SET_RESET: n_out_bits = (r_out_bits & ~wd_hi) | wd_lo;
                REG_RESET:     n_out_bits = r_out_bits & ~wd_lo;
                REG_LOCK: begin
                    if (!r_lock_key) begin
                        n_lock_bits = wd_lo;
                        priority if (r_stage == STG_ONE && !key && same) begin
                            n_stage = STG_TWO;
                        end else if (r_stage == STG_TWO && key && same) begin
                            n_lock_key = 1'b1;
                            n_stage    = STG_IDLE;
                        end else begin
                            n_stage = key ? STG_ONE : STG_IDLE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_low   <= CFG_RESET;
            r_cfg_high  <= CFG_RESET;
            r_out_bits  <= '0;
            r_lock_bits <= '0;
            r_lock_key  <= 1'b0;
            r_stage     <= STG_IDLE;
        end else if (i_fire) begin
            r_cfg_low   <= n_cfg_low;
            r_cfg_high  <= n_cfg_high;
            r_out_bits  <= n_out_bits;
            r_lock_bits <= n_lock_bits;
            r_lock_key  <= n_lock_key;
            r_stage     <= n_stage;
        end
    end

    assign o_res.read_data   = rd;
    assign o_res.lock_active = n_lock_key;

endmodule

FILE: rtl/core/gpio_port_with_config_lock.sv
`timescale 1ns / 1ps

// 16-pin GPIO port with a configuration lock. Each input word is one bus access
// (read or write of a register index) and yields one result word. One access is
// taken per clock while o_stall is low; each access passes through the input
// register and then the result register, with the register file updated as a word
// moves between them. Lock arms after writes of key 1, 0, 1 with equal pin bits and
// holds until reset.
module gpio_port_with_config_lock
    import gpl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_op,
    input  logic [IDX_W-1:0]  i_reg_index,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [PINS-1:0]   i_pin_levels,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_read_data,
    output logic              o_lock_active
);

    logic    r_in_valid;
    t_access r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result res;
    logic    out_free;
    logic    fire;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    gpl_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_acc   (r_in),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in.op         <= i_op;
            r_in.reg_index  <= i_reg_index;
            r_in.write_data <= i_write_data;
            r_in.pin_levels <= i_pin_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_data   = r_out.read_data;
    assign o_lock_active = r_out.lock_active;

endmodule
